FILE: src/interleaved_zero_run_decoder_defines.svh
// assertion macros for the interleaved zero-run decoder
// used by src/interleaved_zero_run_decoder.sv, expects clk and rst in scope
`ifndef INTERLEAVED_ZERO_RUN_DECODER_DEFINES_SVH
`define INTERLEAVED_ZERO_RUN_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define IZRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("izrd assertion failed");

// next-cycle implication, checked out of reset
`define IZRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("izrd assertion failed");

`else

`define IZRD_ASSERT_IMP(lbl, ante, cons)
`define IZRD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/izrd_pkg.sv
// shared types, constants and decode helpers for the interleaved zero-run decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package izrd_pkg;

  localparam int LOOKAHEAD = 11;
  localparam int MIN_RUN   = 10;
  localparam int FILL_W    = $clog2(LOOKAHEAD + 1);

  typedef logic [LOOKAHEAD-1:0][7:0] win_t;
  typedef logic [FILL_W-1:0]         fill_t;

  typedef struct packed {
    logic yield;
    logic decode;
    logic expect_zero;
  } take_t;

  // front of a full window starts a run: even offsets up to MIN_RUN all zero
  function automatic logic qualifies(input win_t w, input fill_t fill);
    logic ok;
    ok = (32'(fill) > MIN_RUN);
    for (int k = 0; k < LOOKAHEAD; k += 2) begin
      if (k <= MIN_RUN && w[k] != 8'h00) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // one step of the decode state on the front byte
  function automatic take_t take_front(input logic [7:0] v, input logic decode,
                                       input logic expect_zero, input logic qual);
    take_t t;
    if (decode && !expect_zero) begin
      t = '{yield: 1'b1, decode: 1'b1, expect_zero: 1'b1};
    end else if (decode && v == 8'h00) begin
      t = '{yield: 1'b0, decode: 1'b1, expect_zero: 1'b0};
    end else if (v == 8'h00 && qual) begin
      t = '{yield: 1'b0, decode: 1'b1, expect_zero: 1'b0};
    end else begin
      t = '{yield: 1'b1, decode: 1'b0, expect_zero: 1'b0};
    end
    return t;
  endfunction

  // drop the front byte, everything moves one place toward the front
  function automatic win_t shift_front(input win_t w);
    win_t s;
    s = w;
    for (int k = 0; k < LOOKAHEAD - 1; k++) begin
      s[k] = w[k+1];
    end
    s[LOOKAHEAD-1] = 8'h00;
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: src/interleaved_zero_run_decoder.sv
// a steady-state item frees the front byte, whose result is registered as the item is accepted
// throughput: one item per cycle while the message streams and the single output register is free
// on a last item the window drains one byte per cycle while the output is not stalled;
// input stalls through the flush, until the window is empty and the held result is loaded
// rst is synchronous, active high; clears fill, decode state, flush state and output valid
// window bytes are payload and hold no reset value
`timescale 1ns / 1ps
`default_nettype none
`include "interleaved_zero_run_decoder_defines.svh"

module interleaved_zero_run_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  // lookahead window and decode state
  izrd_pkg::win_t  win, win_next;
  izrd_pkg::fill_t fill, fill_next;
  logic            decode_active, decode_next;
  logic            expect_zero_slot, expect_next;

  // flush of the window after the last item; the newest result is held back
  // until we know whether another one follows, so it can carry out_last
  logic            flushing, flushing_next;
  logic            held_valid, held_valid_next;
  logic [7:0]      held_byte, held_byte_next;

  // handshake and step control
  logic            out_free;
  logic            in_acc;
  logic            step_steady;
  logic            flush_step;
  logic            flush_end;
  izrd_pkg::win_t  pushed;
  izrd_pkg::take_t tf;

  // value to load into the output register
  logic            load;
  logic [7:0]      load_byte;
  logic            load_last;

  // output register is free when empty or being taken this cycle
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = flushing || !out_free;
  assign in_acc      = in_valid && !in_stall;
  assign step_steady = (fill == izrd_pkg::FILL_W'(izrd_pkg::LOOKAHEAD - 1));
  assign flush_step  = flushing && out_free && (fill != '0);
  assign flush_end   = flushing && out_free && (fill == '0);

  // window with the incoming byte written at the fill position
  always_comb begin
    for (int k = 0; k < izrd_pkg::LOOKAHEAD; k++) begin
      pushed[k] = (fill == izrd_pkg::FILL_W'(k)) ? in_byte : win[k];
    end
  end

  // decode step on the front byte: the pushed window while streaming,
  // the stored window while flushing
  always_comb begin
    if (flushing) begin
      tf = izrd_pkg::take_front(win[0], decode_active, expect_zero_slot,
                                izrd_pkg::qualifies(win, fill));
    end else begin
      tf = izrd_pkg::take_front(pushed[0], decode_active, expect_zero_slot,
                                izrd_pkg::qualifies(pushed, fill + izrd_pkg::FILL_W'(1)));
    end
  end

  always_comb begin
    win_next        = win;
    fill_next       = fill;
    decode_next     = decode_active;
    expect_next     = expect_zero_slot;
    flushing_next   = flushing;
    held_valid_next = held_valid;
    held_byte_next  = held_byte;
    load            = 1'b0;
    load_byte       = pushed[0];
    load_last       = 1'b0;
    if (in_acc) begin
      if (in_last) begin
        // store the final byte, then drain the window
        win_next      = pushed;
        fill_next     = fill + izrd_pkg::FILL_W'(1);
        flushing_next = 1'b1;
      end else if (step_steady) begin
        // window full: the front byte leaves
        win_next    = izrd_pkg::shift_front(pushed);
        decode_next = tf.decode;
        expect_next = tf.expect_zero;
        load        = tf.yield;
        load_byte   = pushed[0];
      end else begin
        // still filling
        win_next  = pushed;
        fill_next = fill + izrd_pkg::FILL_W'(1);
      end
    end else if (flush_step) begin
      win_next    = izrd_pkg::shift_front(win);
      fill_next   = fill - izrd_pkg::FILL_W'(1);
      decode_next = tf.decode;
      expect_next = tf.expect_zero;
      if (tf.yield) begin
        held_valid_next = 1'b1;
        held_byte_next  = win[0];
        if (held_valid) begin
          load      = 1'b1;
          load_byte = held_byte;
        end
      end
    end else if (flush_end) begin
      // window empty: the held result is the final one of the message
      flushing_next   = 1'b0;
      decode_next     = 1'b0;
      expect_next     = 1'b0;
      held_valid_next = 1'b0;
      if (held_valid) begin
        load      = 1'b1;
        load_byte = held_byte;
        load_last = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill             <= '0;
      decode_active    <= 1'b0;
      expect_zero_slot <= 1'b0;
      flushing         <= 1'b0;
      held_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      fill             <= fill_next;
      decode_active    <= decode_next;
      expect_zero_slot <= expect_next;
      flushing         <= flushing_next;
      held_valid       <= held_valid_next;
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win       <= win_next;
    held_byte <= held_byte_next;
    if (out_free && load) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  // window never overfills while streaming
  `IZRD_ASSERT_IMP(a_fill_bound, !flushing, 32'(fill) < izrd_pkg::LOOKAHEAD)
  // a held result exists only during a flush
  `IZRD_ASSERT_IMP(a_held_in_flush, held_valid, flushing)
  // accepting the last item always starts a flush
  `IZRD_ASSERT_NXT(a_last_flush, in_valid && !in_stall && in_last, flushing)

endmodule

`default_nettype wire
